@@ hw/rtl/lkv_cache_pkg.sv @@
package lkv_cache_pkg;

  // Fixed port widths
  localparam int WORD_W = 64;
  localparam int KIND_W = 2;
  localparam int CFG_W  = 5;

  // Default sizing
  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_KEY_BITS   = 64;
  localparam int DEF_VALUE_BITS = 64;

  // Capacity register reset value
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd10;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_PUT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GET = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEL = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_FINISH
  } state_t;

endpackage

@@ hw/rtl/lru_key_value_cache.sv @@
// Channel | Direction | Ports
// --------+-----------+-------------------------------------------------------
// in      | input     | in_valid/in_ready, in_kind, in_key_word, in_value_word
// out     | output    | out_valid/out_ready, out_hit, out_read_value,
//         |           | out_evicted, out_evicted_key
// cfg     | input     | cfg_valid/cfg_ready, cfg_data (capacity limit)
//
// A request passes through the accept step, a sweep through the single read
// port of the key memory, one update step and one result step.
// Reset (rst_n low, synchronous) empties the store and sets capacity to 10.
// A pending output word stalls only the result step; a new request is
// accepted while the previous word still waits in the output register.
module lru_key_value_cache #(
  parameter int ENTRIES    = lkv_cache_pkg::DEF_ENTRIES,
  parameter int KEY_BITS   = lkv_cache_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = lkv_cache_pkg::DEF_VALUE_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [lkv_cache_pkg::KIND_W-1:0]   in_kind,
  input  logic [lkv_cache_pkg::WORD_W-1:0]   in_key_word,
  input  logic [lkv_cache_pkg::WORD_W-1:0]   in_value_word,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_hit,
  output logic [lkv_cache_pkg::WORD_W-1:0]   out_read_value,
  output logic                               out_evicted,
  output logic [lkv_cache_pkg::WORD_W-1:0]   out_evicted_key,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lkv_cache_pkg::CFG_W-1:0]    cfg_data
);
  import lkv_cache_pkg::*;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // Sequencer
  state_t state_r, state_nxt;
  logic [IDX_W:0] scan_cnt_r;
  logic           scan_en, upd_en, fin_load;

  // Request hold
  logic [KIND_W-1:0]     kind_q_r;
  logic [KEY_BITS-1:0]   key_q_r;
  logic [VALUE_BITS-1:0] val_q_r;

  // Entry state
  logic [CFG_W-1:0]  cap_r;
  logic              valid_r   [ENTRIES];
  logic              valid_nxt [ENTRIES];
  logic [RANK_W-1:0] rank_r    [ENTRIES];
  logic [RANK_W-1:0] rank_nxt  [ENTRIES];
  logic [CNT_W-1:0]  occ_r, occ_nxt;

  // Memories
  logic [KEY_BITS-1:0]   key_mem [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem [ENTRIES];
  logic [KEY_BITS-1:0]   key_rd_r;
  logic [VALUE_BITS-1:0] val_rd_r;
  logic                  key_we, val_we;
  logic [IDX_W-1:0]      key_wa, val_wa;

  // Compare stage
  logic              cmp_vld_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              cmp_valid_r;
  logic [RANK_W-1:0] cmp_rank_r;
  logic [CNT_W-1:0]  occ_m1;
  logic              key_match;

  // Sweep results
  logic              hit_found_r, free_found_r;
  logic [IDX_W-1:0]  hit_slot_r, free_slot_r, victim_slot_r;
  logic [RANK_W-1:0] hit_rank_r;
  logic [KEY_BITS-1:0] victim_key_r;

  // Update decisions
  logic [CMP_W-1:0] cap_ext, cap_eff, ent_c;
  logic             is_put, need_evict, evict, ins_ok;
  logic [IDX_W-1:0] ins_slot;

  // Result hold
  logic                  res_hit_r, res_ev_r, res_get_r;
  logic [KEY_BITS-1:0]   res_evk_r;

  // Output register
  logic                  out_valid_r;
  logic                  out_hit_r, out_ev_r;
  logic [WORD_W-1:0]     out_rd_r, out_evk_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_cnt_r == (IDX_W + 1)'(ENTRIES)) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    scan_en  = 1'b0;
    upd_en   = 1'b0;
    fin_load = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_SCAN:   scan_en  = (scan_cnt_r != (IDX_W + 1)'(ENTRIES));
      ST_UPDATE: upd_en   = 1'b1;
      ST_FINISH: fin_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_valid && in_ready) scan_cnt_r <= '0;
      else if (scan_en)         scan_cnt_r <= scan_cnt_r + 1'b1;
    end
  end

  // Capture request word
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_q_r <= in_kind;
      key_q_r  <= in_key_word[KEY_BITS-1:0];
      val_q_r  <= in_value_word[VALUE_BITS-1:0];
    end
  end

  // Capacity register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= CAP_RESET;
    else if (cfg_valid && cfg_ready) cap_r <= cfg_data;
  end

  // Key memory: swept by the scan, written on insert
  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_q_r;
    key_rd_r <= key_mem[scan_cnt_r[IDX_W-1:0]];
  end

  // Value memory: read at the hit slot during update
  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_wa] <= val_q_r;
    val_rd_r <= val_mem[hit_slot_r];
  end

  // Scan issue: valid bit and rank are registered alongside the key read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= scan_en;
    end
    cmp_idx_r   <= scan_cnt_r[IDX_W-1:0];
    cmp_valid_r <= valid_r[scan_cnt_r[IDX_W-1:0]];
    cmp_rank_r  <= rank_r[scan_cnt_r[IDX_W-1:0]];
  end

  // Compare stage: hit, least recent entry, first free slot
  assign occ_m1    = occ_r - 1'b1;
  assign key_match = (key_rd_r == key_q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmp_vld_r) begin
      if (cmp_valid_r && key_match) hit_found_r <= 1'b1;
      if (!cmp_valid_r && !free_found_r) free_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_vld_r) begin
      if (cmp_valid_r && key_match) begin
        hit_slot_r <= cmp_idx_r;
        hit_rank_r <= cmp_rank_r;
      end
      if (cmp_valid_r && cmp_rank_r == occ_m1[RANK_W-1:0]) begin
        victim_slot_r <= cmp_idx_r;
        victim_key_r  <= key_rd_r;
      end
      if (!cmp_valid_r && !free_found_r) free_slot_r <= cmp_idx_r;
    end
  end

  // Effective capacity, clamped to 1..ENTRIES
  assign cap_ext = CMP_W'(cap_r);
  assign ent_c   = CMP_W'(ENTRIES);
  assign cap_eff = (cap_ext == '0) ? CMP_W'(1) : ((cap_ext > ent_c) ? ent_c : cap_ext);

  // Update decisions
  assign is_put     = (kind_q_r == KIND_PUT);
  assign need_evict = (CMP_W'(occ_r) >= cap_eff);
  assign evict      = is_put && !hit_found_r && need_evict;
  assign ins_ok     = evict || free_found_r;
  assign ins_slot   = (evict && !(free_found_r && free_slot_r < victim_slot_r)) ?
                      victim_slot_r : free_slot_r;

  // Memory writes
  always_comb begin
    key_we = upd_en && is_put && !hit_found_r && ins_ok;
    key_wa = ins_slot;
    val_we = upd_en && is_put && (hit_found_r || ins_ok);
    val_wa = hit_found_r ? hit_slot_r : ins_slot;
  end

  // Valid bits, ranks and occupancy
  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    occ_nxt   = occ_r;
    if (upd_en) begin
      case (kind_q_r)
        KIND_PUT: begin
          if (hit_found_r) begin
            for (int j = 0; j < ENTRIES; j++) begin
              if (valid_r[j] && rank_r[j] < hit_rank_r) rank_nxt[j] = rank_r[j] + 1'b1;
            end
            rank_nxt[hit_slot_r] = '0;
          end else if (ins_ok) begin
            // every valid entry moves up by one; the victim holds the top rank and is then cleared
            for (int j = 0; j < ENTRIES; j++) begin
              if (valid_r[j]) rank_nxt[j] = rank_r[j] + 1'b1;
            end
            if (evict) begin
              valid_nxt[victim_slot_r] = 1'b0;
              rank_nxt[victim_slot_r]  = '0;
            end
            valid_nxt[ins_slot] = 1'b1;
            rank_nxt[ins_slot]  = '0;
            occ_nxt = evict ? occ_r : occ_r + 1'b1;
          end
        end
        KIND_GET: begin
          if (hit_found_r) begin
            for (int j = 0; j < ENTRIES; j++) begin
              if (valid_r[j] && rank_r[j] < hit_rank_r) rank_nxt[j] = rank_r[j] + 1'b1;
            end
            rank_nxt[hit_slot_r] = '0;
          end
        end
        KIND_DEL: begin
          if (hit_found_r) begin
            for (int j = 0; j < ENTRIES; j++) begin
              if (valid_r[j] && rank_r[j] > hit_rank_r) rank_nxt[j] = rank_r[j] - 1'b1;
            end
            valid_nxt[hit_slot_r] = 1'b0;
            rank_nxt[hit_slot_r]  = '0;
            occ_nxt = occ_r - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < ENTRIES; j++) begin
        valid_r[j] <= 1'b0;
        rank_r[j]  <= '0;
      end
      occ_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
      occ_r   <= occ_nxt;
    end
  end

  // Result fields settled during update
  always_ff @(posedge clk) begin
    if (upd_en) begin
      res_hit_r <= hit_found_r && (kind_q_r == KIND_PUT || kind_q_r == KIND_GET ||
                                   kind_q_r == KIND_DEL);
      res_get_r <= hit_found_r && (kind_q_r == KIND_GET);
      res_ev_r  <= evict;
      res_evk_r <= evict ? victim_key_r : '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_hit_r <= res_hit_r;
      out_rd_r  <= res_get_r ? WORD_W'(val_rd_r) : '0;
      out_ev_r  <= res_ev_r;
      out_evk_r <= WORD_W'(res_evk_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_rd_r;
  assign out_evicted     = out_ev_r;
  assign out_evicted_key = out_evk_r;

endmodule

@@ verif/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lkv_cache_pkg::*;

  localparam int CLK_PERIOD   = 2;
  localparam int RESET_CYCLES = 7;
  localparam int SLOTS        = DEF_ENTRIES;
  localparam int DRAIN_CYCLES = 2 * (DEF_ENTRIES + 4);
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_WORDS  = 125;
  localparam int MAX_PRINTS   = 50;
  // kind code the block treats as a no-op
  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;
  localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] value;
  } cache_req_t;

  typedef struct packed {
    logic              hit;
    logic [WORD_W-1:0] read_value;
    logic              evicted;
    logic [WORD_W-1:0] evicted_key;
  } cache_resp_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [KIND_W-1:0] in_kind = '0;
  logic [WORD_W-1:0] in_key_word = '0;
  logic [WORD_W-1:0] in_value_word = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_hit;
  logic [WORD_W-1:0] out_read_value;
  logic              out_evicted;
  logic [WORD_W-1:0] out_evicted_key;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data = '0;

  // Pending requests and the responses they are expected to produce
  cache_req_t  req_q[$];
  cache_resp_t resp_q[$];

  // Shadow copy of the cache contents
  logic [WORD_W-1:0] shadow_key[SLOTS];
  logic [WORD_W-1:0] shadow_value[SLOTS];
  bit                shadow_used[SLOTS];
  int unsigned       shadow_age[SLOTS];
  int unsigned       shadow_fill;
  int unsigned       shadow_capacity;

  int send_idle_pct;
  int recv_idle_pct;
  int words_queued;
  int words_checked;
  int err_count;
  int hit_count;
  int evict_count;
  int cap_writes;
  int hold_left;
  bit hold_done;
  int stall_cycles;

  lru_key_value_cache u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_key_word    (in_key_word),
    .in_value_word  (in_value_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .out_evicted_key(out_evicted_key),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mismatch reporting: one line each, printing capped
  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("[%0t] MISMATCH %s: got 0x%016h want 0x%016h", $time, what, got, want);
  endtask

  // Move slot s to most recent; newer entries age by one
  function automatic void promote_slot(input int s);
    int unsigned r;
    r = shadow_age[s];
    for (int i = 0; i < SLOTS; i++)
      if (shadow_used[i] && shadow_age[i] < r) shadow_age[i]++;
    shadow_age[s] = 0;
  endfunction

  // Free slot s; older entries move up by one
  function automatic void drop_slot(input int s);
    int unsigned r;
    r = shadow_age[s];
    shadow_used[s] = 1'b0;
    shadow_age[s] = 0;
    for (int i = 0; i < SLOTS; i++)
      if (shadow_used[i] && shadow_age[i] > r) shadow_age[i]--;
    if (shadow_fill > 0) shadow_fill--;
  endfunction

  // Apply one request to the shadow cache and return the response it should produce
  function automatic cache_resp_t lru_lookup(input logic [KIND_W-1:0] kind,
                                             input logic [WORD_W-1:0] key,
                                             input logic [WORD_W-1:0] value);
    cache_resp_t r;
    int found;
    int victim;
    int free_slot;
    int unsigned eff_cap;
    r = '0;
    eff_cap = shadow_capacity;
    if (eff_cap < 1) eff_cap = 1;
    if (eff_cap > SLOTS) eff_cap = SLOTS;
    found = -1;
    for (int i = SLOTS - 1; i >= 0; i--)
      if (shadow_used[i] && shadow_key[i] == key) found = i;
    case (kind)
      KIND_PUT: begin
        if (found >= 0) begin
          r.hit = 1'b1;
          shadow_value[found] = value;
          promote_slot(found);
        end else begin
          // full (or over a lowered limit): evict the least recent entry
          if (shadow_fill >= eff_cap) begin
            victim = -1;
            for (int i = 0; i < SLOTS; i++)
              if (shadow_used[i] && (victim < 0 || shadow_age[i] > shadow_age[victim]))
                victim = i;
            if (victim >= 0) begin
              r.evicted = 1'b1;
              r.evicted_key = shadow_key[victim];
              drop_slot(victim);
            end
          end
          // insert at the lowest free slot as most recent
          free_slot = -1;
          for (int i = SLOTS - 1; i >= 0; i--)
            if (!shadow_used[i]) free_slot = i;
          if (free_slot >= 0) begin
            for (int j = 0; j < SLOTS; j++)
              if (shadow_used[j]) shadow_age[j]++;
            shadow_used[free_slot] = 1'b1;
            shadow_key[free_slot] = key;
            shadow_value[free_slot] = value;
            shadow_age[free_slot] = 0;
            shadow_fill++;
          end
        end
      end
      KIND_GET: begin
        if (found >= 0) begin
          r.hit = 1'b1;
          r.read_value = shadow_value[found];
          promote_slot(found);
        end
      end
      KIND_DEL: begin
        if (found >= 0) begin
          r.hit = 1'b1;
          drop_slot(found);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Request driver: predicts on each accepted word, then offers the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        resp_q.insert(resp_q.size(), lru_lookup(in_kind, in_key_word, in_value_word));
      if (!in_valid || in_ready) begin
        if (req_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid      <= 1'b1;
          in_kind       <= req_q[0].kind;
          in_key_word   <= req_q[0].key;
          in_value_word <= req_q[0].value;
          void'(req_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor with random back-pressure and one long hold-off
  always @(posedge clk) begin
    cache_resp_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (resp_q.size() == 0) begin
          report_mismatch("unexpected word", out_read_value, '0);
        end else begin
          want = resp_q.pop_front();
          words_checked++;
          if (want.hit) hit_count++;
          if (want.evicted) evict_count++;
          if (out_hit !== want.hit)
            report_mismatch("hit", WORD_W'(out_hit), WORD_W'(want.hit));
          if (out_read_value !== want.read_value)
            report_mismatch("read_value", out_read_value, want.read_value);
          if (out_evicted !== want.evicted)
            report_mismatch("evicted", WORD_W'(out_evicted), WORD_W'(want.evicted));
          if (out_evicted_key !== want.evicted_key)
            report_mismatch("evicted_key", out_evicted_key, want.evicted_key);
        end
      end
      if (!hold_done && words_checked >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout after %0d idle cycles, %0d words pending", stall_cycles, resp_q.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic queue_request(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] key,
                               input logic [WORD_W-1:0] value);
    cache_req_t r;
    r.kind = kind;
    r.key = key;
    r.value = value;
    req_q.insert(req_q.size(), r);
    words_queued++;
  endtask

  // Wait until every queued request has come back, then let the block settle
  task automatic wait_drained();
    while (words_checked != words_queued) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] cap);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_capacity = cap;
    cap_writes++;
  endtask

  // Random traffic over a small key set so that hits and evictions are common
  task automatic random_phase(input logic [CFG_W-1:0] cap, input int pool_size);
    logic [WORD_W-1:0] key_pool[$];
    logic [WORD_W-1:0] key;
    logic [KIND_W-1:0] kind;
    int pick;
    wait_drained();
    write_capacity(cap);
    for (int i = 0; i < pool_size; i++) key_pool.insert(key_pool.size(), {$urandom, $urandom});
    for (int n = 0; n < PHASE_WORDS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) kind = KIND_PUT;
      else if (pick < 80) kind = KIND_GET;
      else if (pick < 95) kind = KIND_DEL;
      else kind = KIND_NOP;
      if ($urandom_range(0, 9) == 0) key = {$urandom, $urandom};
      else key = key_pool[$urandom_range(0, pool_size - 1)];
      queue_request(kind, key, {$urandom, $urandom});
    end
  endtask

  initial begin
    shadow_capacity = CAP_RESET;
    shadow_fill = 0;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_used[i] = 1'b0;
      shadow_age[i] = 0;
    end
    send_idle_pct = 20;
    recv_idle_pct = 70;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset capacity, key and value extremes, every kind
    queue_request(KIND_PUT, '0, ALL_ONES);
    queue_request(KIND_PUT, ALL_ONES, '0);
    queue_request(KIND_GET, '0, '0);
    queue_request(KIND_GET, ALL_ONES, ALL_ONES);
    queue_request(KIND_GET, 64'h5555_5555_5555_5555, '0);
    queue_request(KIND_PUT, '0, 64'hA5A5_A5A5_A5A5_A5A5);
    queue_request(KIND_DEL, ALL_ONES, ALL_ONES);
    queue_request(KIND_DEL, ALL_ONES, '0);
    queue_request(KIND_NOP, '0, ALL_ONES);
    queue_request(KIND_GET, '0, '0);
    wait_drained();
    // zero capacity behaves as one entry: each new key evicts the previous
    write_capacity(5'd0);
    queue_request(KIND_PUT, 64'h5555_5555_5555_5555, 64'h0123_4567_89AB_CDEF);
    queue_request(KIND_GET, '0, '0);
    queue_request(KIND_GET, 64'h5555_5555_5555_5555, '0);
    queue_request(KIND_PUT, 64'hAAAA_AAAA_AAAA_AAAA, 64'hFEDC_BA98_7654_3210);

    // Random phases; large capacity followed by small ones to exceed the limit
    random_phase(5'd16, 24);
    random_phase(5'd31, 28);
    random_phase(5'd2, 6);
    wait_drained();
    send_idle_pct = 70;
    recv_idle_pct = 20;
    random_phase(5'd1, 3);
    random_phase(5'd17, 22);
    random_phase(5'd5, 10);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(5'd12, 18);
    random_phase(CFG_W'($urandom_range(0, 31)), $urandom_range(2, 24));

    wait_drained();
    if (resp_q.size() != 0)
      report_mismatch("words never returned", WORD_W'(resp_q.size()), '0);
    $display("Checked %0d requests over %0d capacity writes: %0d hits, %0d evictions",
             words_checked, cap_writes, hit_count, evict_count);
    $display("Included a %0d-cycle output hold-off with the input kept busy", HOLD_CYCLES);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ lru_key_value_cache.f @@
hw/rtl/lkv_cache_pkg.sv
hw/rtl/lru_key_value_cache.sv
verif/tb_top.sv
